// ===== rtl/slri_pkg.sv =====
package slri_pkg;

    localparam int KIND_W   = 2;
    localparam int VAL_W    = 32;
    localparam int POS_W    = 5;
    localparam int STATUS_W = 2;
    localparam int IDX_W    = 4;

    // Operation codes on the request channel
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LIST   = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd3;

    // Commands from the controller to the cell row
    typedef enum logic [1:0] {
        OP_NONE   = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2,
        OP_ROTATE = 2'd3
    } op_t;

    typedef struct packed {
        op_t                     op;
        logic signed [VAL_W-1:0] value;
        logic [POS_W-1:0]        position;
    } cmd_t;

    typedef struct packed {
        logic                    full;
        logic                    empty;
        logic                    pos_bad;
        logic signed [VAL_W-1:0] head;
        logic [IDX_W-1:0]        head_idx;
        logic                    head_last;
    } stat_t;

endpackage

// ===== rtl/slri_if.sv =====
interface slri_req_if;
    import slri_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [KIND_W-1:0]       kind;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        position;

    modport source (output valid, output kind, output value, output position, input ready);
    modport sink   (input valid, input kind, input value, input position, output ready);
endinterface

interface slri_rsp_if;
    import slri_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [STATUS_W-1:0]     status;
    logic signed [VAL_W-1:0] element;
    logic [IDX_W-1:0]        index;
    logic                    last;

    modport source (output valid, output status, output element, output index, output last,
                    input ready);
    modport sink   (input valid, input status, input element, input index, input last,
                    output ready);
endinterface

// ===== rtl/slri_dp.sv =====
module slri_dp #(
    parameter int CAPACITY = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  slri_pkg::cmd_t cmd,
    output slri_pkg::stat_t stat
);
    import slri_pkg::*;

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    logic signed [VAL_W-1:0] cell_reg  [CAPACITY];
    logic signed [VAL_W-1:0] cell_next [CAPACITY];
    logic [CW-1:0]           count_reg, count_next;
    logic [CW-1:0]           lidx_reg, lidx_next;
    logic [CAPACITY-1:0]     gt;
    logic                    lidx_last;

    // Flag occupied cells holding a value greater than the incoming one
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            gt[i] = (CW'(i) < count_reg) && (cell_reg[i] > cmd.value);
        end
    end

    // Per-cell next value: shift up on insert, shift down on remove, rotate on list
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic                    prev_gt;
        logic signed [VAL_W-1:0] prev_cell;
        logic signed [VAL_W-1:0] next_cell;

        if (g == 0)
        begin : g_first
            assign prev_gt   = 1'b0;
            assign prev_cell = cell_reg[g];
        end
        else
        begin : g_mid
            assign prev_gt   = gt[g-1];
            assign prev_cell = cell_reg[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_top
            assign next_cell = cell_reg[g];
        end
        else
        begin : g_low
            assign next_cell = cell_reg[g+1];
        end

        always_comb
        begin
            cell_next[g] = cell_reg[g];
            unique case (cmd.op)
                OP_INSERT:
                begin
                    if (prev_gt)
                        cell_next[g] = prev_cell;
                    else if (gt[g] || (CW'(g) == count_reg))
                        cell_next[g] = cmd.value;
                end
                OP_REMOVE:
                begin
                    if ((CMPW'(g) >= CMPW'(cmd.position)) && (CW'(g + 1) < count_reg))
                        cell_next[g] = next_cell;
                end
                OP_ROTATE:
                begin
                    if (CW'(g) < count_reg)
                        cell_next[g] = (CW'(g + 1) == count_reg) ? cell_reg[0] : next_cell;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign lidx_last = (CW'(lidx_reg + CW'(1)) == count_reg);

    // Track the fill count and the listing position
    always_comb
    begin
        count_next = count_reg;
        lidx_next  = lidx_reg;
        unique case (cmd.op)
            OP_INSERT: count_next = CW'(count_reg + CW'(1));
            OP_REMOVE: count_next = CW'(count_reg - CW'(1));
            OP_ROTATE: lidx_next  = lidx_last ? '0 : CW'(lidx_reg + CW'(1));
            default:
            begin
            end
        endcase
    end

    // Hold the cell row
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            cell_reg[i] <= cell_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            lidx_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            lidx_reg  <= lidx_next;
        end
    end

    // Report occupancy, the position check and the head of the row
    assign stat.full      = (count_reg == CW'(CAPACITY));
    assign stat.empty     = (count_reg == '0);
    assign stat.pos_bad   = (CMPW'(cmd.position) >= CMPW'(count_reg));
    assign stat.head      = cell_reg[0];
    assign stat.head_idx  = IDX_W'(lidx_reg);
    assign stat.head_last = lidx_last;

endmodule

// ===== rtl/slri_ctrl.sv =====
module slri_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    slri_req_if.sink        req,
    slri_rsp_if.source      rsp,
    output slri_pkg::cmd_t  cmd,
    input  slri_pkg::stat_t stat
);
    import slri_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_LIST = 2'b10
    } state_t;

    state_t                  state_reg, state_next;
    logic                    vld_reg, vld_next;
    logic [STATUS_W-1:0]     status_reg, status_next;
    logic signed [VAL_W-1:0] element_reg, element_next;
    logic [IDX_W-1:0]        index_reg, index_next;
    logic                    last_reg, last_next;
    logic                    out_free;
    logic                    req_fire;

    assign out_free  = !vld_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE) && out_free;
    assign req_fire  = req.valid && req.ready;

    // Decode requests, issue cell commands and load the result register
    always_comb
    begin
        state_next   = state_reg;
        vld_next     = vld_reg && !rsp.ready;
        status_next  = status_reg;
        element_next = element_reg;
        index_next   = index_reg;
        last_next    = last_reg;
        cmd.op       = OP_NONE;
        cmd.value    = req.value;
        cmd.position = req.position;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    vld_next     = 1'b1;
                    status_next  = ST_OK;
                    element_next = '0;
                    index_next   = '0;
                    last_next    = 1'b1;
                    unique case (req.kind)
                        KIND_INSERT:
                        begin
                            if (stat.full)
                                status_next = ST_FULL;
                            else
                                cmd.op = OP_INSERT;
                        end
                        KIND_REMOVE:
                        begin
                            priority if (stat.empty)
                                status_next = ST_EMPTY;
                            else if (stat.pos_bad)
                                status_next = ST_BADPOS;
                            else
                                cmd.op = OP_REMOVE;
                        end
                        KIND_LIST:
                        begin
                            if (stat.empty)
                                status_next = ST_EMPTY;
                            else
                            begin
                                vld_next   = 1'b0;
                                state_next = S_LIST;
                            end
                        end
                        default:
                        begin
                            // unused kind: drop it
                            vld_next = 1'b0;
                        end
                    endcase
                end
            end
            S_LIST:
            begin
                if (out_free)
                begin
                    vld_next     = 1'b1;
                    status_next  = ST_OK;
                    element_next = stat.head;
                    index_next   = stat.head_idx;
                    last_next    = stat.head_last;
                    cmd.op       = OP_ROTATE;
                    if (stat.head_last)
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            vld_reg   <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg  <= status_next;
        element_reg <= element_next;
        index_reg   <= index_next;
        last_reg    <= last_next;
    end

    assign rsp.valid   = vld_reg;
    assign rsp.status  = status_reg;
    assign rsp.element = element_reg;
    assign rsp.index   = index_reg;
    assign rsp.last    = last_reg;

endmodule

// ===== rtl/sorted_list_insert_remove_top.sv =====
// Insert and remove: one request per cycle while the result side takes results; the
//   status result is registered and shows in the cycle after the request transfer.
// List of n entries: n results, one per cycle while the result side takes them,
//   paced by one rotation of the cell row per result; requests wait until the last.
// Reset clears the entry count and control state; stored values stay undefined.
module sorted_list_insert_remove_top #(
    parameter int CAPACITY = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    slri_req_if.sink   req,
    slri_rsp_if.source rsp
);
    import slri_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    slri_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cmd   (cmd),
        .stat  (stat)
    );

    slri_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .stat  (stat)
    );

    // Never insert into a full row
    a_no_insert_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_INSERT |-> !stat.full)
        else $error("insert issued on full list");

    // Remove only at a valid position
    a_remove_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_REMOVE |-> !stat.empty && !stat.pos_bad)
        else $error("remove issued at invalid position");

    // Error results always close their request
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status != ST_OK |-> rsp.last)
        else $error("error result without last");

    // A list of a non-empty row blocks new requests next cycle
    a_list_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready && req.kind == KIND_LIST && !stat.empty |=> !req.ready)
        else $error("request taken during listing");

endmodule
